// ===== rtl/core/mis_pkg.sv =====
// Shared types and constants of the merge-insertion sorter.
// Used by mis_cell and merge_insertion_sorter; depends on nothing else.
package mis_pkg;

  localparam int unsigned MisMaxItems = 64;
  localparam int unsigned ValW        = 31;

  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StDup = 2'd1,
    StOvf = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    logic            ins;     // place ins_val at its rank
    logic            shift;   // move every word one cell toward the head
    logic [ValW-1:0] ins_val;
  } mis_ctrl_t;

endpackage

// ===== rtl/core/merge_insertion_sorter.sv =====
// Top level of the streaming sorter: control sequencer and the cell chain.
// Depends on mis_pkg and mis_cell.
//
//  channel  | dir | tdata (low bit up)           | tlast      | tuser
//  ---------+-----+------------------------------+------------+---------------
//  s_axis   | in  | value[30:0], zero pad [31]   | last       | -
//  m_axis   | out | value_res[30:0], pad [31]    | last_res   | status[1:0]
//
// Each input word is compared against every cell at once and placed at its
// rank in the same clock edge as the chain shifts right. After the marked
// word the chain drains one result per cycle from its head while
// m_axis_tready is high; an errored run sends the single error word instead.
// Input is held off (s_axis_tready low) while results are pending. Reset
// clears the count, error and sequencer state; cell contents are not reset
// and are only read below the count.
module merge_insertion_sorter #(
  parameter int unsigned MAX_ITEMS = mis_pkg::MisMaxItems
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[30:0], pad[31]
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // value_res[30:0], pad[31]
  output logic        m_axis_tlast_o,   // last_res
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import mis_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    Fill,
    Drain,
    ErrOut
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  status_e         err_q;

  mis_ctrl_t             ctrl;
  logic [MAX_ITEMS-1:0]  keep;
  logic [MAX_ITEMS-1:0]  eq;
  logic [MAX_ITEMS-1:0]  occ;
  logic [ValW-1:0]       cell_val [MAX_ITEMS];

  logic    in_hs;
  logic    out_hs;
  logic    dup;
  logic    full;
  logic    ins_ok;
  status_e err_new;

  assign in_hs  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o & m_axis_tready_i;
  assign dup    = |eq;
  assign full   = (count_q == CntW'(MAX_ITEMS));

  // Duplicate wins over overflow; a held error masks everything after it.
  always_comb begin
    err_new = err_q;
    if (err_q == StOk) begin
      if (dup) begin
        err_new = StDup;
      end else if (full) begin
        err_new = StOvf;
      end
    end
  end

  assign ins_ok = in_hs & (err_q == StOk) & ~dup & ~full;

  assign ctrl.ins     = ins_ok;
  assign ctrl.shift   = out_hs & (state_q == Drain);
  assign ctrl.ins_val = s_axis_tdata_i[ValW-1:0];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic            left_keep;
    logic [ValW-1:0] left_val;
    logic [ValW-1:0] right_val;

    assign occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_val  = ctrl.ins_val;
    end else begin : g_body
      assign left_keep = keep[i-1];
      assign left_val  = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    mis_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .left_keep_i (left_keep),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .keep_o      (keep[i]),
      .eq_o        (eq[i]),
      .val_o       (cell_val[i])
    );
  end

  // Sequencer: fill the chain, then drain it or send the single error word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Fill;
      count_q <= '0;
      err_q   <= StOk;
    end else begin
      case (state_q)
        Fill: begin
          if (in_hs) begin
            if (s_axis_tlast_i) begin
              if (err_new != StOk) begin
                state_q <= ErrOut;
                count_q <= '0;
                err_q   <= err_new;
              end else begin
                state_q <= Drain;
                count_q <= count_q + CntW'(1);
              end
            end else begin
              err_q   <= err_new;
              count_q <= count_q + CntW'(ins_ok);
            end
          end
        end
        Drain: begin
          if (out_hs) begin
            count_q <= count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              state_q <= Fill;
            end
          end
        end
        ErrOut: begin
          if (out_hs) begin
            state_q <= Fill;
            err_q   <= StOk;
          end
        end
        default: begin
          state_q <= Fill;
          count_q <= '0;
          err_q   <= StOk;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == Fill);
  assign m_axis_tvalid_o = (state_q != Fill);
  assign m_axis_tdata_o  = (state_q == Drain) ? {1'b0, cell_val[0]} : 32'd0;
  assign m_axis_tlast_o  = (state_q == ErrOut) | (count_q == CntW'(1));
  assign m_axis_tuser_o  = (state_q == ErrOut) ? err_q : StOk;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("item count above capacity");

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Drain) |-> (count_q != '0))
    else $error("draining an empty chain");

  a_one_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input open while results pending");

  a_err_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != StOk) |->
      (m_axis_tdata_o == 32'd0 && m_axis_tlast_o))
    else $error("error word malformed");

  a_reopen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
      (s_axis_tready_o && count_q == '0))
    else $error("chain not reopened after final word");
`endif

endmodule

// ===== rtl/core/mis_cell.sv =====
// One cell of the systolic insertion chain: holds one sorted value.
// Depends on mis_pkg for the broadcast command type and the value width.
module mis_cell (
  input  logic                      clk_i,
  input  mis_pkg::mis_ctrl_t        ctrl_i,
  input  logic                      occ_i,
  input  logic                      left_keep_i,
  input  logic [mis_pkg::ValW-1:0]  left_val_i,
  input  logic [mis_pkg::ValW-1:0]  right_val_i,
  output logic                      keep_o,
  output logic                      eq_o,
  output logic [mis_pkg::ValW-1:0]  val_o
);
  import mis_pkg::*;

  logic [ValW-1:0] val_q;
  logic [ValW-1:0] val_d;

  // A held value below the new one stays; the first cell that does not
  // keep takes the new value, the ones after it take their left neighbor.
  assign keep_o = occ_i & (val_q < ctrl_i.ins_val);
  assign eq_o   = occ_i & (val_q == ctrl_i.ins_val);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.ins && !keep_o) begin
      val_d = left_keep_i ? ctrl_i.ins_val : left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
